// ===== src/pidai_pkg.sv =====
// Shared widths, register indexes and constants for the asymmetric-integral PID controller.
package pidai_pkg;

  localparam int MEAS_W  = 16;
  localparam int CFG_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DELTA_W = 18;
  localparam int ACC_W   = 32;
  localparam int DRIVE_W = 40;
  localparam int SUM_W   = 42;
  localparam int IPROD_W = 48;
  localparam int CIDX_W  = 3;

  // Register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_TARGET      = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_GAIN_P      = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_GAIN_I      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_GAIN_D      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_INTEG_UPPER = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_INTEG_LOWER = 3'd5;

  // Reset values of the registers
  localparam logic signed [CFG_W-1:0] TARGET_RST      = 16'sd0;
  localparam logic signed [CFG_W-1:0] GAIN_P_RST      = 16'sd256;
  localparam logic signed [CFG_W-1:0] GAIN_I_RST      = 16'sd0;
  localparam logic signed [CFG_W-1:0] GAIN_D_RST      = 16'sd2560;
  localparam logic signed [CFG_W-1:0] INTEG_UPPER_RST = 16'sd200;
  localparam logic signed [CFG_W-1:0] INTEG_LOWER_RST = -16'sd200;

  // |err| * 256 / 200 = |err| * 32 / 25, done as (|err| * RECIP) >> RECIP_SHIFT.
  // RECIP = ceil(2^26 / 25); exact for |err| below 2^16.
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 21;
  localparam int QPROD_W     = (MEAS_W) + RECIP_W;
  localparam int QMAG_W      = 17;
  localparam logic [RECIP_W-1:0] RECIP = 22'd2684355;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 42'sh007F_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -42'sh0080_0000_0000;

endpackage

// ===== src/pidai_if.sv =====
// Valid/ready channel interfaces for measurement items and drive items.
interface pidai_in_if;
  import pidai_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measurement;
  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface pidai_out_if;
  import pidai_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== src/pid_controller_asym_integral_top.sv =====
// PID controller with asymmetric integral gain and rise-gated derivative: top level.
//
// Usage:
//   in_item  : valid/ready sink, one signed Q8.8 measurement per item.
//   out_item : valid/ready source, one signed Q24.16 drive per item, saturating.
//   cfg_*    : write-only port, cfg_we with cfg_index and cfg_data; writes take
//              effect at the next edge. Writing the set point clears the integrator.
// Path: an accepted item is loaded into the input register, and its drive is
//   registered into drive_r when it advances, which a stalled output can hold off.
// Throughput: one item per cycle unless out_item.ready stalls. Integrator update
//   (error times reciprocal, add, clamp) is combinational: each item sees the prior state.
// Reset (rst_n low, synchronous): both stages empty, registers to their defaults,
//   integrator, previous error and previous measurement to zero.
// Stall: while out_item.ready is low the drive is held; the input register still
//   takes one more item, after which in_item.ready drops until the output drains.
module pid_controller_asym_integral_top (
  input  logic                          clk,
  input  logic                          rst_n,
  pidai_in_if.sink                      in_item,
  pidai_out_if.source                   out_item,
  input  logic                          cfg_we,
  input  logic [pidai_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [pidai_pkg::CFG_W-1:0]   cfg_data
);
  import pidai_pkg::*;

  logic                      in_valid_r;
  logic signed [MEAS_W-1:0]  meas_r;
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;

  logic signed [CFG_W-1:0]   target_r;
  logic signed [CFG_W-1:0]   gain_p_r;
  logic signed [CFG_W-1:0]   gain_i_r;
  logic signed [CFG_W-1:0]   gain_d_r;
  logic signed [CFG_W-1:0]   integ_upper_r;
  logic signed [CFG_W-1:0]   integ_lower_r;

  logic signed [ACC_W-1:0]   integ_acc_r;
  logic signed [ACC_W-1:0]   integ_acc_nxt;
  logic signed [ERR_W-1:0]   prev_error_r;
  logic signed [MEAS_W-1:0]  prev_meas_r;

  logic                      advance;
  logic signed [ERR_W-1:0]   err;
  logic                      err_pos;
  logic [MEAS_W-1:0]         err_mag;
  logic [QPROD_W-1:0]        q_prod;
  logic [QMAG_W-1:0]         q_mag;
  logic signed [QMAG_W:0]    step;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W:0]     acc_hi;
  logic signed [ACC_W:0]     acc_lo;
  logic signed [IPROD_W-1:0] i_prod;
  logic signed [IPROD_W-1:0] i_adj;
  logic signed [IPROD_W-1:0] i_shift;
  logic signed [DRIVE_W-1:0] i_term;
  logic signed [ERR_W+CFG_W-1:0]   p_term;
  logic signed [DELTA_W-1:0]       delta;
  logic signed [DELTA_W+CFG_W-1:0] d_term;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DRIVE_W-1:0] drive_nxt;

  assign advance        = in_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready  = !in_valid_r || advance;
  assign out_item.valid = out_valid_r;
  assign out_item.drive = drive_r;

  always_comb begin
    err     = ERR_W'(target_r) - ERR_W'(meas_r);
    err_pos = !err[ERR_W-1] && (err != '0);
    err_mag = err[ERR_W-1] ? MEAS_W'(-err) : MEAS_W'(err);

    // Integrator step: error * 256 / 200, truncated toward zero
    q_prod  = QPROD_W'(err_mag) * QPROD_W'(RECIP);
    q_mag   = q_prod[RECIP_SHIFT +: QMAG_W];
    step    = err[ERR_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    acc_sum = (ACC_W+1)'(integ_acc_r) + (ACC_W+1)'(step);
    acc_hi  = $signed({{1{integ_upper_r[CFG_W-1]}}, integ_upper_r, 16'h0000});
    acc_lo  = $signed({{1{integ_lower_r[CFG_W-1]}}, integ_lower_r, 16'h0000});
    // Upper limit first, then lower
    if (acc_sum > acc_hi) begin
      integ_acc_nxt = ACC_W'(acc_hi);
    end else if (acc_sum < acc_lo) begin
      integ_acc_nxt = ACC_W'(acc_lo);
    end else begin
      integ_acc_nxt = ACC_W'(acc_sum);
    end

    // I term: divide by 256, or by 512 when error is not positive, toward zero
    i_prod = IPROD_W'(gain_i_r) * IPROD_W'(integ_acc_r);
    if (i_prod[IPROD_W-1]) begin
      i_adj = i_prod + (err_pos ? IPROD_W'(255) : IPROD_W'(511));
    end else begin
      i_adj = i_prod;
    end
    i_shift = err_pos ? (i_adj >>> 8) : (i_adj >>> 9);
    i_term  = DRIVE_W'(i_shift);

    p_term = (ERR_W+CFG_W)'(gain_p_r) * (ERR_W+CFG_W)'(err);
    delta  = DELTA_W'(err) - DELTA_W'(prev_error_r);
    // Derivative only when the measurement did not rise
    if (prev_meas_r >= meas_r) begin
      d_term = (DELTA_W+CFG_W)'(gain_d_r) * (DELTA_W+CFG_W)'(delta);
    end else begin
      d_term = '0;
    end

    sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    if (sum > SUM_MAX) begin
      drive_nxt = DRIVE_W'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      drive_nxt = DRIVE_W'(SUM_MIN);
    end else begin
      drive_nxt = DRIVE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      target_r      <= TARGET_RST;
      gain_p_r      <= GAIN_P_RST;
      gain_i_r      <= GAIN_I_RST;
      gain_d_r      <= GAIN_D_RST;
      integ_upper_r <= INTEG_UPPER_RST;
      integ_lower_r <= INTEG_LOWER_RST;
      integ_acc_r   <= '0;
      prev_error_r  <= '0;
      prev_meas_r   <= '0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        in_valid_r <= 1'b1;
        meas_r     <= in_item.measurement;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r  <= 1'b1;
        drive_r      <= drive_nxt;
        integ_acc_r  <= integ_acc_nxt;
        prev_error_r <= err;
        prev_meas_r  <= meas_r;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET: begin
            target_r    <= $signed(cfg_data);
            integ_acc_r <= '0;
          end
          CFG_GAIN_P:      gain_p_r      <= $signed(cfg_data);
          CFG_GAIN_I:      gain_i_r      <= $signed(cfg_data);
          CFG_GAIN_D:      gain_d_r      <= $signed(cfg_data);
          CFG_INTEG_UPPER: integ_upper_r <= $signed(cfg_data);
          CFG_INTEG_LOWER: integ_lower_r <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_sp_clears_integ: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == CFG_TARGET) |=> integ_acc_r == '0)
    else $error("integrator not cleared by set point write");

  a_integ_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_we && (integ_lower_r <= integ_upper_r) |=>
      (integ_acc_r <= ACC_W'(acc_hi)) && (integ_acc_r >= ACC_W'(acc_lo)))
    else $error("integrator outside its limits");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> in_valid_r && out_valid_r && !out_item.ready)
    else $error("input held off without a stalled output");

  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item did not reach the output register");
`endif

endmodule
